// ===== rtl/tnsc_pkg.sv =====
// Package for the traction notch speed controller.
// Types, register codes and fixed-point constants shared by all rtl files.
package tnsc_pkg;

    // Field widths
    localparam int SPEED_W   = 16;
    localparam int CURR_W    = 13;
    localparam int PRESS_W   = 10;
    localparam int BAND_W    = 10;
    localparam int GAIN_W    = 32;
    localparam int CUTOFF_W  = 12;
    localparam int TICKS_W   = 16;
    localparam int NOTCH_W   = 4;
    localparam int INTEG_W   = 16;
    localparam int DV_W      = SPEED_W + 1;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Shared multiplier operands and product
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 27;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = 51;

    localparam logic [NOTCH_W-1:0] MAX_NOTCH = 4'd15;

    localparam logic [PRESS_W-1:0]   PRESSURE_LOCK_KPA = 10'd40;
    localparam logic signed [DV_W-1:0] RELOCK_SPEED    = 17'sd1000;
    localparam logic [CURR_W-1:0]    MIN_REF_CURRENT   = 13'd100;
    localparam logic signed [ACC_W-1:0] UNIT_SCALE     = 51'sd6553600;
    // floor(x/100) == (x * RECIP_100) >> 32, exact for x < 2^24
    localparam logic [MUL_A_W-1:0]   RECIP_100         = 33'd42949673;
    // |integ_gain_dt * dv| at or above this gives an increment past any clamp
    localparam logic [MUL_P_W-1:0]   INC_SAT_LIMIT     = 60'd26214400;
    localparam logic [17:0]          INC_SAT_MAG       = 18'd131072;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CURRENT      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_BAND     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN_DT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OVERSPEED_GAIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OVERSPEED_CUTOFF = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_TICKS    = 3'd6;

    typedef struct packed {
        logic [CURR_W-1:0]   max_current;
        logic [BAND_W-1:0]   current_band;
        logic [GAIN_W-1:0]   prop_gain;
        logic [GAIN_W-1:0]   integ_gain_dt;
        logic [GAIN_W-1:0]   overspeed_gain;
        logic [CUTOFF_W-1:0] overspeed_cutoff;
        logic [TICKS_W-1:0]  holdoff_ticks;
    } cfg_t;

    // Per-tick inputs to the notch logic
    typedef struct packed {
        logic [PRESS_W-1:0]     pressure;
        logic signed [DV_W-1:0] dv;
        logic [CURR_W-1:0]      iref;
        logic [CURR_W-1:0]      igen;
    } tick_t;

    // Notch and lock after the tick
    typedef struct packed {
        logic [NOTCH_W-1:0] notch;
        logic               locked;
    } notch_stat_t;

    typedef struct packed {
        logic [NOTCH_W-1:0] notch;
        logic               running;
        logic [TICKS_W-1:0] count;
    } hold_t;

endpackage

// ===== rtl/tnsc_mul.sv =====
// Shared signed multiplier with registered product.
// Depends on tnsc_pkg for operand widths.
module tnsc_mul (
    input  logic                                 clk,
    input  logic signed [tnsc_pkg::MUL_A_W-1:0]  a,
    input  logic signed [tnsc_pkg::MUL_B_W-1:0]  b,
    output logic signed [tnsc_pkg::MUL_P_W-1:0]  p
);
    import tnsc_pkg::*;

    logic signed [MUL_P_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// ===== rtl/tnsc_notch.sv =====
// Notch position, traction lock and hold-off timer.
// Applies the tick's requests in order on commit. Depends on tnsc_pkg.
module tnsc_notch (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  commit,
    input  tnsc_pkg::cfg_t        cfg,
    input  tnsc_pkg::tick_t       tick,
    output tnsc_pkg::notch_stat_t stat_next
);
    import tnsc_pkg::*;

    logic [NOTCH_W-1:0] notch_reg, notch_next;
    logic               lock_reg, lock_next;
    logic               run_reg, run_next;
    logic [TICKS_W-1:0] count_reg, count_next;

    function automatic hold_t f_zero(input hold_t s);
        hold_t r;
        r = s;
        if (s.running)
        begin
            r.running = 1'b0;
            r.count   = '0;
        end
        else
        begin
            r.notch   = '0;
            r.running = 1'b1;
            r.count   = '0;
        end
        return r;
    endfunction

    function automatic hold_t f_up(input hold_t s);
        hold_t r;
        r = s;
        if (!s.running)
        begin
            if (s.notch < MAX_NOTCH)
                r.notch = s.notch + 1'b1;
            r.running = 1'b1;
            r.count   = '0;
        end
        return r;
    endfunction

    function automatic hold_t f_down(input hold_t s);
        hold_t r;
        r = s;
        if (!s.running)
        begin
            if (s.notch != '0)
                r.notch = s.notch - 1'b1;
            r.running = 1'b1;
            r.count   = '0;
        end
        return r;
    endfunction

    always_comb
    begin
        hold_t                s;
        logic                 lk;
        logic [CURR_W:0]      igen_band;
        logic [CURR_W:0]      iref_band;
        logic signed [DV_W:0] dv_x;
        logic signed [DV_W:0] neg_cut;
        logic [TICKS_W:0]     cnt_inc;

        s.notch   = notch_reg;
        s.running = run_reg;
        s.count   = count_reg;
        lk        = lock_reg;
        igen_band = {1'b0, tick.igen} + {4'b0, cfg.current_band};
        iref_band = {1'b0, tick.iref} + {4'b0, cfg.current_band};
        dv_x      = {tick.dv[DV_W-1], tick.dv};
        neg_cut   = -$signed({{(DV_W+1-CUTOFF_W){1'b0}}, cfg.overspeed_cutoff});

        if (tick.pressure > PRESSURE_LOCK_KPA)
        begin
            lk = 1'b1;
            s  = f_zero(s);
        end
        else
        begin
            lk = lk && (tick.dv < RELOCK_SPEED);
        end

        if (tick.iref < MIN_REF_CURRENT)
            s = f_zero(s);
        if ((igen_band < {1'b0, tick.iref}) && !lk)
            s = f_up(s);
        if ({1'b0, tick.igen} > iref_band)
            s = f_down(s);
        if (dv_x < neg_cut)
            s = f_zero(s);

        // timer counts after the requests; expires once holdoff_ticks are counted
        cnt_inc = {1'b0, s.count} + 1'b1;
        if (s.running)
        begin
            if (cnt_inc >= {1'b0, cfg.holdoff_ticks})
            begin
                s.running = 1'b0;
                s.count   = '0;
            end
            else
            begin
                s.count = cnt_inc[TICKS_W-1:0];
            end
        end

        notch_next = s.notch;
        lock_next  = lk;
        run_next   = s.running;
        count_next = s.count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            notch_reg <= '0;
            lock_reg  <= 1'b0;
            run_reg   <= 1'b0;
            count_reg <= '0;
        end
        else if (commit)
        begin
            notch_reg <= notch_next;
            lock_reg  <= lock_next;
            run_reg   <= run_next;
            count_reg <= count_next;
        end
    end

    assign stat_next.notch  = notch_next;
    assign stat_next.locked = lock_next;

endmodule

// ===== rtl/traction_notch_speed_controller.sv =====
// Traction notch speed controller top level: sequencer, config registers,
// integrator and output register. Uses tnsc_pkg, tnsc_mul and tnsc_notch.
//
// Usage: one input word per control tick on s_tvalid/s_tready/s_tdata, one
// result word per tick on m_tvalid/m_tready/m_tdata. Registers are written
// through cfg_we/cfg_index/cfg_data while no tick is in flight.
// Sequence: an accepted word passes the accept cycle, then seven steps
// of the sequencer around one shared 33x27 multiplier (proportional term,
// overspeed term, integral increment, reference scaling and two divides by
// 100 by reciprocal multiplication). The result is registered into m_tdata
// at the commit that ends the final step; s_tready returns in that same cycle.
// A new word is not accepted until the previous one has left the sequencer.
// A new word is accepted while the previous result still waits in the output
// register; if that result is still untaken when the next one is ready, the
// sequencer holds in its last step and s_tready stays low until m_tready.
// Reset: registers return to their default values, integrator, notch, lock
// and hold-off timer clear, and the output register empties.
module traction_notch_speed_controller (
    input  logic                             clk,
    input  logic                             rst_n,
    // target_speed[15:0], current_speed[31:16], predicted_speed[47:32],
    // generator_current[60:48], cylinder_pressure[70:61], motion_allowed[71],
    // vigilance_request[72], zero fill [79:73]
    input  logic [tnsc_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // notch_position[3:0], current_reference[16:4], traction_locked[17],
    // motion_allowed[18], vigilance_request[19], zero fill [23:20]
    output logic [tnsc_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             cfg_we,
    input  logic [tnsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tnsc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tnsc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_M1   = 3'd1;
    localparam logic [2:0] ST_M2   = 3'd2;
    localparam logic [2:0] ST_M3   = 3'd3;
    localparam logic [2:0] ST_T    = 3'd4;
    localparam logic [2:0] ST_D1   = 3'd5;
    localparam logic [2:0] ST_D2   = 3'd6;
    localparam logic [2:0] ST_FIN  = 3'd7;

    logic [2:0] state_reg, state_next;

    cfg_t cfg_reg;

    logic signed [DV_W-1:0]    dv_reg;
    logic [SPEED_W-1:0]        dvs_reg;
    logic [CURR_W-1:0]         igen_reg;
    logic [PRESS_W-1:0]        press_reg;
    logic                      motion_reg;
    logic                      vigil_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    logic                      t_zero_reg;
    logic                      t_big_reg;
    logic [CURR_W-1:0]         iref_reg;
    logic                      int_neg_reg;
    logic                      int_sat_reg;
    logic [23:0]               int_x_reg;
    logic [OUT_DATA_W-1:0]     out_reg;
    logic                      out_valid_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;

    logic                      in_acc;
    logic                      commit;
    logic [SPEED_W-1:0]        in_target, in_cur, in_pred;
    logic signed [ACC_W-1:0]   integ_x;
    logic [MUL_P_W-1:0]        int_mag;
    logic [17:0]               inc_mag;
    logic signed [19:0]        integ_sum;
    logic signed [INTEG_W-1:0] integ_new;
    tick_t                     tick;
    notch_stat_t               stat_next;

    assign in_target = s_tdata[15:0];
    assign in_cur    = s_tdata[31:16];
    assign in_pred   = s_tdata[47:32];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign commit   = (state_reg == ST_FIN) && (!out_valid_reg || m_tready);

    // 200 * integrator
    assign integ_x = ({{(ACC_W-INTEG_W){integ_reg[INTEG_W-1]}}, integ_reg} <<< 7)
                   + ({{(ACC_W-INTEG_W){integ_reg[INTEG_W-1]}}, integ_reg} <<< 6)
                   + ({{(ACC_W-INTEG_W){integ_reg[INTEG_W-1]}}, integ_reg} <<< 3);

    // Operand select for the shared multiplier
    always_comb
    begin
        unique case (state_reg)
            ST_M1:
            begin
                mul_a = $signed({1'b0, cfg_reg.prop_gain});
                mul_b = $signed({{(MUL_B_W-DV_W){dv_reg[DV_W-1]}}, dv_reg});
            end
            ST_M2:
            begin
                mul_a = $signed({1'b0, cfg_reg.overspeed_gain});
                mul_b = $signed({{(MUL_B_W-SPEED_W){1'b0}}, dvs_reg});
            end
            ST_M3:
            begin
                mul_a = $signed({1'b0, cfg_reg.integ_gain_dt});
                mul_b = $signed({{(MUL_B_W-DV_W){dv_reg[DV_W-1]}}, dv_reg});
            end
            ST_T:
            begin
                mul_a = $signed({{(MUL_A_W-CURR_W){1'b0}}, cfg_reg.max_current});
                mul_b = $signed({4'b0, acc_reg[22:0]});
            end
            ST_D1:
            begin
                // (max_current * t) >> 16, then divide by 100
                mul_a = $signed(RECIP_100);
                mul_b = $signed({7'b0, prod[35:16]});
            end
            default:
            begin
                mul_a = $signed(RECIP_100);
                mul_b = $signed({3'b0, int_x_reg});
            end
        endcase
    end

    tnsc_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // Integrator increment magnitude: |integ_gain_dt * dv| / 200, toward zero
    assign int_mag = prod[MUL_P_W-1] ? (~prod + 1'b1) : prod;
    assign inc_mag = int_sat_reg ? INC_SAT_MAG : prod[49:32];

    always_comb
    begin
        integ_sum = {{4{integ_reg[INTEG_W-1]}}, integ_reg}
                  + (int_neg_reg ? -$signed({2'b0, inc_mag}) : $signed({2'b0, inc_mag}));
        if (integ_sum > 20'sd32767)
            integ_new = 16'sh7FFF;
        else if (integ_sum < -20'sd32768)
            integ_new = 16'sh8000;
        else
            integ_new = integ_sum[INTEG_W-1:0];
    end

    assign tick.pressure = press_reg;
    assign tick.dv       = dv_reg;
    assign tick.iref     = iref_reg;
    assign tick.igen     = igen_reg;

    tnsc_notch u_notch (
        .clk       (clk),
        .rst_n     (rst_n),
        .commit    (commit),
        .cfg       (cfg_reg),
        .tick      (tick),
        .stat_next (stat_next)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_acc) state_next = ST_M1;
            ST_M1:   state_next = ST_M2;
            ST_M2:   state_next = ST_M3;
            ST_M3:   state_next = ST_T;
            ST_T:    state_next = ST_D1;
            ST_D1:   state_next = ST_D2;
            ST_D2:   state_next = ST_FIN;
            ST_FIN:  if (commit) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            integ_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
                integ_reg     <= integ_new;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_current      <= 13'd5000;
            cfg_reg.current_band     <= 10'd100;
            cfg_reg.prop_gain        <= 32'd65536;
            cfg_reg.integ_gain_dt    <= 32'd655;
            cfg_reg.overspeed_gain   <= 32'd65536;
            cfg_reg.overspeed_cutoff <= 12'd300;
            cfg_reg.holdoff_ticks    <= 16'd100;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_CURRENT:      cfg_reg.max_current      <= cfg_data[CURR_W-1:0];
                REG_CURRENT_BAND:     cfg_reg.current_band     <= cfg_data[BAND_W-1:0];
                REG_PROP_GAIN:        cfg_reg.prop_gain        <= cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN_DT:    cfg_reg.integ_gain_dt    <= cfg_data[GAIN_W-1:0];
                REG_OVERSPEED_GAIN:   cfg_reg.overspeed_gain   <= cfg_data[GAIN_W-1:0];
                REG_OVERSPEED_CUTOFF: cfg_reg.overspeed_cutoff <= cfg_data[CUTOFF_W-1:0];
                REG_HOLDOFF_TICKS:    cfg_reg.holdoff_ticks    <= cfg_data[TICKS_W-1:0];
                default:              ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            dv_reg     <= $signed({1'b0, in_target}) - $signed({1'b0, in_cur});
            dvs_reg    <= (in_pred > in_cur) ? (in_pred - in_cur) : '0;
            igen_reg   <= s_tdata[60:48];
            press_reg  <= s_tdata[70:61];
            motion_reg <= s_tdata[71];
            vigil_reg  <= s_tdata[72];
            acc_reg    <= integ_x;
        end
        if (state_reg == ST_M2)
            acc_reg <= acc_reg + prod[ACC_W-1:0];
        if (state_reg == ST_M3)
            acc_reg <= acc_reg - prod[ACC_W-1:0];
        if (state_reg == ST_T)
        begin
            t_zero_reg  <= acc_reg[ACC_W-1] || (acc_reg == '0);
            t_big_reg   <= (acc_reg >= UNIT_SCALE);
            int_neg_reg <= prod[MUL_P_W-1];
            int_sat_reg <= (int_mag >= INC_SAT_LIMIT);
            int_x_reg   <= int_mag[24:1];
        end
        if (state_reg == ST_D2)
        begin
            if (t_zero_reg)
                iref_reg <= '0;
            else if (t_big_reg)
                iref_reg <= cfg_reg.max_current;
            else
                iref_reg <= prod[32 +: CURR_W];
        end
        if (commit)
            out_reg <= {4'b0, vigil_reg, motion_reg, stat_next.locked, iref_reg,
                        stat_next.notch};
    end

    assign m_tdata  = out_reg;
    assign m_tvalid = out_valid_reg;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while sequencer busy");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_FIN))
        else $error("result written outside final step");

    a_iref_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[16:4] <= cfg_reg.max_current))
        else $error("current reference above max_current");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) && out_valid_reg && !m_tready |=> (state_reg == ST_FIN))
        else $error("sequencer left final step while output stalled");
`endif

endmodule
